// File: rtl/tdc_ehb_pkg.sv
package tdc_ehb_pkg;

	// Channel store geometry
	localparam int NUM_CHANNELS = 32;
	localparam int CH_W = $clog2(NUM_CHANNELS);

	// Field widths
	localparam int TIME_W = 24;
	localparam int TOT_W = 23;
	localparam int CHAN_W = 8;
	localparam int EVENT_W = 32;
	localparam int COUNT_W = 16;
	localparam int DIFF_W = TIME_W + 1;
	localparam int ALU_W = TIME_W + 2;
	localparam int CFG_ADDR_W = 3;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 104;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_ACCEPT_LOW = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ACCEPT_HIGH = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SPIKE_MIN = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_CUT_LOW = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_CUT_HIGH = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_TOT_LIMIT = 3'd5;

	// Register reset values
	localparam logic [TIME_W-1:0] ACCEPT_LOW_RST = TIME_W'(-800000);
	localparam logic [TIME_W-1:0] ACCEPT_HIGH_RST = TIME_W'(800000);
	localparam logic [TOT_W-1:0] SPIKE_MIN_RST = TOT_W'(80000);
	localparam logic [TIME_W-1:0] CUT_LOW_RST = TIME_W'(-4000000);
	localparam logic [TIME_W-1:0] CUT_HIGH_RST = TIME_W'(4000000);
	localparam logic [TOT_W-1:0] TOT_LIMIT_RST = TOT_W'(8388607);

	localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Input kinds
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_END = 1'b1;

	// Requests from the sequencer to the channel store
	typedef struct packed {
		logic [CH_W-1:0] addr;
		logic open;
		logic close;
		logic keep;
		logic clear;
		logic [TIME_W-1:0] lead;
		logic [TOT_W-1:0] tot;
	} st_ctl_t;

	// Per-channel flags at the store address
	typedef struct packed {
		logic rise;
		logic fall;
		logic kept;
	} st_flags_t;

endpackage

// File: rtl/tdc_edge_pair_hit_builder_top.sv
// TDC edge pairing and hit builder.
// Input stream s_*: an edge message (channel, rising flag, time in ps) or an
// end-of-event request, selected by s_tuser. Edges on channel 0 or beyond the
// channel count are dropped. A rising edge inside the acceptance window opens
// a pulse on its channel, the next falling edge closes it, and the pulse is
// kept when its time over threshold exceeds spike_min.
// Output stream m_*: on end of event, one request per kept hit that passes the
// lead and ToT cuts, in ascending channel order, with m_tlast on the last one,
// or a single empty marker (hit flag low) when no hit passes.
// One shared subtract unit does all time and ToT arithmetic. A rising edge
// tests the low, then the high window bound; a falling edge subtracts its lead,
// then tests spike_min. An end of event reads each channel, tests a kept hit
// against the lead and ToT cuts, and waits while the output is stalled.
// s_tready is high only while the sequencer is idle. One output register parts
// the two sides: a stalled receiver holds the current request and blocks the
// scan only when the next request is ready.
// Reset clears the channel flags, the event and edge counters and loads the
// default window, spike and cut registers. Config writes are taken at any cycle.
module tdc_edge_pair_hit_builder_top import tdc_ehb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [TIME_W-1:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	// channel[7:0], rising[8], time_ps[32:9], zero fill above
	input  logic [IN_DATA_W-1:0] s_tdata,
	// op[0]
	input  logic [0:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// hit_channel[7:0], lead_time[31:8], tot_ps[54:32], event_number[86:55],
	// rising_count[102:87], zero fill above
	output logic [OUT_DATA_W-1:0] m_tdata,
	// hit_valid[0]
	output logic [0:0] m_tuser,
	output logic m_tlast
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RISE_LO,
		S_RISE_HI,
		S_FALL_SUB,
		S_FALL_CMP,
		S_SCAN_RD,
		S_SCAN_LO,
		S_SCAN_HI,
		S_SCAN_TOT,
		S_PUSH,
		S_FLUSH
	} state_t;

	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);
	localparam logic [CH_W-1:0] FIRST_CH = CH_W'(1);

	state_t state_q;

	logic [TIME_W-1:0] accept_low_q;
	logic [TIME_W-1:0] accept_high_q;
	logic [TOT_W-1:0] spike_min_q;
	logic [TIME_W-1:0] cut_low_q;
	logic [TIME_W-1:0] cut_high_q;
	logic [TOT_W-1:0] tot_limit_q;

	logic [CH_W-1:0] ch_q;
	logic [TIME_W-1:0] time_q;
	logic [DIFF_W-1:0] tot_q;
	logic [CH_W-1:0] scan_q;
	logic [EVENT_W-1:0] event_cnt_q;
	logic [COUNT_W-1:0] edge_cnt_q;

	logic pend_vld_q;
	logic [CH_W-1:0] pend_ch_q;
	logic [TIME_W-1:0] pend_lead_q;
	logic [TOT_W-1:0] pend_tot_q;

	logic out_vld_q;
	logic out_hit_q;
	logic out_last_q;
	logic [CHAN_W-1:0] out_ch_q;
	logic [TIME_W-1:0] out_lead_q;
	logic [TOT_W-1:0] out_tot_q;
	logic [EVENT_W-1:0] out_event_q;
	logic [COUNT_W-1:0] out_count_q;

	logic in_op;
	logic [CHAN_W-1:0] in_ch;
	logic in_rise;
	logic [TIME_W-1:0] in_time;
	logic in_ok;
	logic accept;

	logic signed [ALU_W-1:0] alu_a;
	logic signed [ALU_W-1:0] alu_b;
	logic signed [ALU_W-1:0] alu_y;
	logic alu_neg;

	st_ctl_t st_ctl;
	st_flags_t st_flags;
	logic [TIME_W-1:0] st_cand;
	logic [TIME_W-1:0] st_lead;
	logic [TOT_W-1:0] st_tot;

	logic out_free;
	logic out_load;
	logic scan_end;
	state_t scan_next;
	logic [TOT_W-1:0] tot_sat;

	// Unpack the input request
	assign in_op = s_tuser[0];
	assign in_ch = s_tdata[CHAN_W-1:0];
	assign in_rise = s_tdata[CHAN_W];
	assign in_time = s_tdata[CHAN_W+TIME_W:CHAN_W+1];
	assign in_ok = (in_ch != '0) && (in_ch < CHAN_W'(NUM_CHANNELS));
	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;

	assign out_free = !out_vld_q || m_tready;
	assign out_load = out_free && ((state_q == S_PUSH) || (state_q == S_FLUSH));
	assign scan_end = (scan_q == LAST_CH);
	assign scan_next = scan_end ? S_FLUSH : S_SCAN_RD;
	assign tot_sat = tot_q[TOT_W] ? TOT_MAX : tot_q[TOT_W-1:0];

	// Select operands of the shared subtract unit; every compare is a - b < 0
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		unique case (state_q)
			S_RISE_LO: begin
				alu_a = ALU_W'($signed(accept_low_q));
				alu_b = ALU_W'($signed(time_q));
			end
			S_RISE_HI: begin
				alu_a = ALU_W'($signed(time_q));
				alu_b = ALU_W'($signed(accept_high_q));
			end
			S_FALL_SUB: begin
				alu_a = ALU_W'($signed(time_q));
				alu_b = ALU_W'($signed(st_cand));
			end
			S_FALL_CMP: begin
				alu_a = ALU_W'(spike_min_q);
				alu_b = ALU_W'($signed(tot_q));
			end
			S_SCAN_LO: begin
				alu_a = ALU_W'($signed(cut_low_q));
				alu_b = ALU_W'($signed(st_lead));
			end
			S_SCAN_HI: begin
				alu_a = ALU_W'($signed(st_lead));
				alu_b = ALU_W'($signed(cut_high_q));
			end
			S_SCAN_TOT: begin
				alu_a = ALU_W'(st_tot);
				alu_b = ALU_W'(tot_limit_q);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	assign alu_y = alu_a - alu_b;
	assign alu_neg = alu_y[ALU_W-1];

	// Build store requests
	always_comb begin
		st_ctl = '0;
		st_ctl.lead = st_cand;
		st_ctl.tot = tot_sat;
		unique case (state_q)
			S_IDLE: st_ctl.addr = in_ch[CH_W-1:0];
			S_RISE_LO, S_RISE_HI, S_FALL_SUB, S_FALL_CMP: st_ctl.addr = ch_q;
			default: st_ctl.addr = scan_q;
		endcase
		if (state_q == S_RISE_HI) begin
			st_ctl.open = alu_neg;
			st_ctl.lead = time_q;
		end
		st_ctl.close = (state_q == S_FALL_SUB);
		st_ctl.keep = (state_q == S_FALL_CMP) && alu_neg;
		st_ctl.clear = (state_q == S_FLUSH) && out_free;
	end

	tdc_ehb_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (st_ctl),
		.flags  (st_flags),
		.cand   (st_cand),
		.lead   (st_lead),
		.tot    (st_tot)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_low_q <= ACCEPT_LOW_RST;
			accept_high_q <= ACCEPT_HIGH_RST;
			spike_min_q <= SPIKE_MIN_RST;
			cut_low_q <= CUT_LOW_RST;
			cut_high_q <= CUT_HIGH_RST;
			tot_limit_q <= TOT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ACCEPT_LOW: accept_low_q <= cfg_wdata;
				REG_ACCEPT_HIGH: accept_high_q <= cfg_wdata;
				REG_SPIKE_MIN: spike_min_q <= cfg_wdata[TOT_W-1:0];
				REG_CUT_LOW: cut_low_q <= cfg_wdata;
				REG_CUT_HIGH: cut_high_q <= cfg_wdata;
				REG_TOT_LIMIT: tot_limit_q <= cfg_wdata[TOT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, counters, pending hit and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q <= '0;
			time_q <= '0;
			tot_q <= '0;
			scan_q <= '0;
			event_cnt_q <= '0;
			edge_cnt_q <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
			out_hit_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			// drop the shown request once taken, unless a new one replaces it
			if (out_vld_q && m_tready && !out_load) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ch_q <= in_ch[CH_W-1:0];
						time_q <= in_time;
						if (in_op == OP_END) begin
							scan_q <= FIRST_CH;
							pend_vld_q <= 1'b0;
							state_q <= S_SCAN_RD;
						end else if (in_ok && in_rise) begin
							if (edge_cnt_q != COUNT_MAX) begin
								edge_cnt_q <= edge_cnt_q + 1'b1;
							end
							if (!st_flags.kept) begin
								state_q <= S_RISE_LO;
							end
						end else if (in_ok && st_flags.rise && !st_flags.fall) begin
							state_q <= S_FALL_SUB;
						end
					end
				end
				S_RISE_LO: state_q <= alu_neg ? S_RISE_HI : S_IDLE;
				S_RISE_HI: state_q <= S_IDLE;
				S_FALL_SUB: begin
					tot_q <= alu_y[DIFF_W-1:0];
					state_q <= S_FALL_CMP;
				end
				S_FALL_CMP: state_q <= S_IDLE;
				S_SCAN_RD: begin
					if (st_flags.kept) begin
						state_q <= S_SCAN_LO;
					end else begin
						scan_q <= scan_q + 1'b1;
						state_q <= scan_next;
					end
				end
				S_SCAN_LO, S_SCAN_HI: begin
					if (alu_neg) begin
						state_q <= (state_q == S_SCAN_LO) ? S_SCAN_HI : S_SCAN_TOT;
					end else begin
						scan_q <= scan_q + 1'b1;
						state_q <= scan_next;
					end
				end
				S_SCAN_TOT: begin
					if (alu_neg && pend_vld_q) begin
						state_q <= S_PUSH;
					end else begin
						if (alu_neg) begin
							pend_vld_q <= 1'b1;
							pend_ch_q <= scan_q;
							pend_lead_q <= st_lead;
							pend_tot_q <= st_tot;
						end
						scan_q <= scan_q + 1'b1;
						state_q <= scan_next;
					end
				end
				S_PUSH: begin
					// hand the older hit out, hold the new one as pending
					if (out_free) begin
						out_vld_q <= 1'b1;
						out_hit_q <= 1'b1;
						out_last_q <= 1'b0;
						out_ch_q <= CHAN_W'(pend_ch_q);
						out_lead_q <= pend_lead_q;
						out_tot_q <= pend_tot_q;
						out_event_q <= event_cnt_q;
						out_count_q <= edge_cnt_q;
						pend_ch_q <= scan_q;
						pend_lead_q <= st_lead;
						pend_tot_q <= st_tot;
						scan_q <= scan_q + 1'b1;
						state_q <= scan_next;
					end
				end
				S_FLUSH: begin
					// close the event with the pending hit or an empty marker
					if (out_free) begin
						out_vld_q <= 1'b1;
						out_hit_q <= pend_vld_q;
						out_last_q <= 1'b1;
						out_ch_q <= pend_vld_q ? CHAN_W'(pend_ch_q) : '0;
						out_lead_q <= pend_vld_q ? pend_lead_q : '0;
						out_tot_q <= pend_vld_q ? pend_tot_q : '0;
						out_event_q <= event_cnt_q;
						out_count_q <= edge_cnt_q;
						pend_vld_q <= 1'b0;
						event_cnt_q <= event_cnt_q + 1'b1;
						edge_cnt_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser[0] = out_hit_q;
	assign m_tlast = out_last_q;
	assign m_tdata = {1'b0, out_count_q, out_event_q, out_tot_q, out_lead_q, out_ch_q};

`ifndef SYNTH
	// a pulse is kept only right after its falling edge closed it
	a_keep_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		st_ctl.keep |-> $past(st_ctl.close))
		else $error("hit kept without a closing edge");

	// the store clear ends the event and resets the edge count
	a_clear_resets_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_ctl.clear |=> (edge_cnt_q == '0) && (state_q == S_IDLE))
		else $error("edge count not cleared at end of event");

	// an empty marker is always the last request of its event
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata[CHAN_W-1:0] == '0)))
		else $error("empty marker not last or carries a channel");

	// channel 0 is never scanned or written
	a_no_chan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_ctl.open || st_ctl.keep || state_q == S_SCAN_LO) |-> (st_ctl.addr != '0))
		else $error("channel 0 touched");
`endif

endmodule

// File: rtl/tdc_ehb_store.sv
module tdc_ehb_store import tdc_ehb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  st_ctl_t ctl,
	output st_flags_t flags,
	output logic [TIME_W-1:0] cand,
	output logic [TIME_W-1:0] lead,
	output logic [TOT_W-1:0] tot
);

	logic [NUM_CHANNELS-1:0] rise_q;
	logic [NUM_CHANNELS-1:0] fall_q;
	logic [NUM_CHANNELS-1:0] kept_q;

	logic [TIME_W-1:0] cand_mem [NUM_CHANNELS];
	logic [TIME_W-1:0] lead_mem [NUM_CHANNELS];
	logic [TOT_W-1:0] tot_mem [NUM_CHANNELS];

	// Update the per-channel pairing flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= '0;
			fall_q <= '0;
			kept_q <= '0;
		end else if (ctl.clear) begin
			rise_q <= '0;
			fall_q <= '0;
			kept_q <= '0;
		end else begin
			if (ctl.open) begin
				rise_q[ctl.addr] <= 1'b1;
				fall_q[ctl.addr] <= 1'b0;
			end
			if (ctl.close) begin
				fall_q[ctl.addr] <= 1'b1;
			end
			if (ctl.keep) begin
				kept_q[ctl.addr] <= 1'b1;
			end
		end
	end

	// Write the time memories and register their read data
	always_ff @(posedge clk) begin
		if (ctl.open) begin
			cand_mem[ctl.addr] <= ctl.lead;
		end
		if (ctl.keep) begin
			lead_mem[ctl.addr] <= ctl.lead;
			tot_mem[ctl.addr] <= ctl.tot;
		end
		cand <= cand_mem[ctl.addr];
		lead <= lead_mem[ctl.addr];
		tot <= tot_mem[ctl.addr];
	end

	assign flags.rise = rise_q[ctl.addr];
	assign flags.fall = fall_q[ctl.addr];
	assign flags.kept = kept_q[ctl.addr];

endmodule

// File: bench/tdc_edge_pair_hit_builder_top_test.sv
`timescale 1ns / 1ps

module tdc_edge_pair_hit_builder_top_test;
	import tdc_ehb_pkg::*;

	localparam int TIME_TOP = 8388607;
	localparam int TIME_BOTTOM = -8388608;
	localparam int TOT_CEIL = (1 << TOT_W) - 1;
	localparam int DRAIN_CYCLES = 16;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 14;
	localparam int NUM_PHASES = 7;
	localparam int LONG_HOLD = 2000;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

	// One result request as seen on the output stream
	typedef struct {
		logic hit;
		logic [CHAN_W-1:0] chan;
		logic [TIME_W-1:0] lead;
		logic [TOT_W-1:0] tot;
		logic [EVENT_W-1:0] evt;
		logic [COUNT_W-1:0] rises;
		logic last;
	} hit_rec_t;

	// Pairs edges per channel and predicts the hits each end of event releases
	class hit_scoreboard;
		int acc_lo, acc_hi, spike, cut_lo, cut_hi, tot_lim;
		bit rise_on[NUM_CHANNELS];
		bit fall_on[NUM_CHANNELS];
		bit kept[NUM_CHANNELS];
		int lead_open[NUM_CHANNELS];
		int lead_kept[NUM_CHANNELS];
		int tot_kept[NUM_CHANNELS];
		logic [EVENT_W-1:0] evt_ctr;
		int rise_ctr;
		hit_rec_t pending_hits[$];
		int mismatches;
		int hits_seen;
		int empties_seen;

		function new();
			acc_lo = int'($signed(ACCEPT_LOW_RST));
			acc_hi = int'($signed(ACCEPT_HIGH_RST));
			spike = int'(SPIKE_MIN_RST);
			cut_lo = int'($signed(CUT_LOW_RST));
			cut_hi = int'($signed(CUT_HIGH_RST));
			tot_lim = int'(TOT_LIMIT_RST);
			evt_ctr = '0;
			mismatches = 0;
			hits_seen = 0;
			empties_seen = 0;
			clear_channels();
		endfunction

		function void clear_channels();
			foreach (rise_on[c]) begin
				rise_on[c] = 1'b0;
				fall_on[c] = 1'b0;
				kept[c] = 1'b0;
			end
			rise_ctr = 0;
		endfunction

		function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [TIME_W-1:0] d);
			case (idx)
				REG_ACCEPT_LOW: acc_lo = int'($signed(d));
				REG_ACCEPT_HIGH: acc_hi = int'($signed(d));
				REG_SPIKE_MIN: spike = int'(d[TOT_W-1:0]);
				REG_CUT_LOW: cut_lo = int'($signed(d));
				REG_CUT_HIGH: cut_hi = int'($signed(d));
				REG_TOT_LIMIT: tot_lim = int'(d[TOT_W-1:0]);
				default: ;
			endcase
		endfunction

		// Update the channel store for an accepted request; queue hits on end of event
		function void note_request(logic op, logic [CHAN_W-1:0] ch, logic rise,
				logic [TIME_W-1:0] t);
			int tv;
			int tot;
			int n;
			hit_rec_t r;
			if (op == OP_END) begin
				n = 0;
				for (int c = 1; c < NUM_CHANNELS; c++) begin
					if (kept[c] && lead_kept[c] > cut_lo && lead_kept[c] < cut_hi
							&& tot_kept[c] < tot_lim) begin
						r.hit = 1'b1;
						r.chan = CHAN_W'(c);
						r.lead = TIME_W'(lead_kept[c]);
						r.tot = TOT_W'(tot_kept[c]);
						r.evt = evt_ctr;
						r.rises = COUNT_W'(rise_ctr);
						r.last = 1'b0;
						pending_hits.push_back(r);
						n++;
					end
				end
				if (n == 0) begin
					r.hit = 1'b0;
					r.chan = '0;
					r.lead = '0;
					r.tot = '0;
					r.evt = evt_ctr;
					r.rises = COUNT_W'(rise_ctr);
					r.last = 1'b1;
					pending_hits.push_back(r);
				end else begin
					r = pending_hits.pop_back();
					r.last = 1'b1;
					pending_hits.push_back(r);
				end
				clear_channels();
				evt_ctr++;
				return;
			end
			// Drop channel 0 and channels beyond the store
			if (ch == 0 || ch >= NUM_CHANNELS)
				return;
			tv = int'($signed(t));
			if (rise) begin
				if (rise_ctr < TOT_CEIL && rise_ctr < int'(COUNT_MAX))
					rise_ctr++;
				if (!kept[ch] && tv > acc_lo && tv < acc_hi) begin
					rise_on[ch] = 1'b1;
					fall_on[ch] = 1'b0;
					lead_open[ch] = tv;
				end
			end else if (rise_on[ch] && !fall_on[ch]) begin
				// Close the pulse; keep it only above the spike threshold
				tot = tv - lead_open[ch];
				fall_on[ch] = 1'b1;
				if (tot > spike) begin
					lead_kept[ch] = lead_open[ch];
					tot_kept[ch] = (tot > TOT_CEIL) ? TOT_CEIL : tot;
					kept[ch] = 1'b1;
				end
			end
		endfunction

		task report_mismatch(string what, logic [EVENT_W-1:0] got, logic [EVENT_W-1:0] want);
			$display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
			mismatches++;
		endtask

		// Compare one result request against the oldest expected hit
		task check_hit(hit_rec_t got);
			hit_rec_t want;
			if (pending_hits.size() == 0) begin
				report_mismatch("result with nothing expected, channel",
					EVENT_W'(got.chan), '0);
				return;
			end
			want = pending_hits.pop_front();
			if (want.hit)
				hits_seen++;
			else
				empties_seen++;
			if (got.hit !== want.hit)
				report_mismatch("hit flag", EVENT_W'(got.hit), EVENT_W'(want.hit));
			if (got.chan !== want.chan)
				report_mismatch("hit channel", EVENT_W'(got.chan), EVENT_W'(want.chan));
			if (got.lead !== want.lead)
				report_mismatch("lead time", EVENT_W'(got.lead), EVENT_W'(want.lead));
			if (got.tot !== want.tot)
				report_mismatch("time over threshold", EVENT_W'(got.tot),
					EVENT_W'(want.tot));
			if (got.evt !== want.evt) report_mismatch("event number", got.evt, want.evt);
			if (got.rises !== want.rises)
				report_mismatch("rising count", EVENT_W'(got.rises), EVENT_W'(want.rises));
			if (got.last !== want.last)
				report_mismatch("last flag", EVENT_W'(got.last), EVENT_W'(want.last));
		endtask

		task close_out();
			if (pending_hits.size() != 0)
				report_mismatch("results never delivered, count", pending_hits.size(), '0);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [TIME_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tlast;

	hit_scoreboard sb;
	bit tx_gaps;
	bit rx_gaps;
	int hold_req;
	int edge_reqs;
	int end_reqs;
	int analysed_items;
	int phases_run;

	tdc_edge_pair_hit_builder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int rand_time();
		logic [TIME_W-1:0] raw;
		raw = TIME_W'($urandom);
		return int'($signed(raw));
	endfunction

	// Offer one request and hold it until the block takes it
	task automatic send_item(logic op, int ch, bit rise, int t);
		logic [CHAN_W-1:0] c8;
		logic [TIME_W-1:0] t24;
		int gap;
		c8 = CHAN_W'(ch);
		t24 = TIME_W'(t);
		gap = tx_gaps ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_DATA_W'({t24, rise, c8});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(op, c8, rise, t24);
		if (op == OP_END) begin
			end_reqs++;
			analysed_items++;
		end else begin
			edge_reqs++;
			if (c8 != 0 && c8 < NUM_CHANNELS)
				analysed_items++;
		end
	endtask

	task automatic send_noise();
		send_item(OP_EDGE, $urandom_range(0, 255), $urandom_range(0, 1), rand_time());
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v[TIME_W-1:0];
		sb.set_reg(idx, v[TIME_W-1:0]);
		@(posedge clk);
	endtask

	// Stop offering and wait until every expected result has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One event of rising/falling pairs with random content, plus noise, then end of event
	task automatic play_event(int pairs, bit every_channel);
		int chs[NUM_CHANNELS];
		int leads[NUM_CHANNELS];
		int falls[NUM_CHANNELS];
		int k;
		int lo;
		int hi;
		int tot;
		int pick;
		int mode;
		longint f;
		bit grouped;
		mode = $urandom_range(0, 3);
		tx_gaps = (mode == 0 || mode == 1);
		rx_gaps = (mode == 0 || mode == 2);
		lo = sb.acc_lo + 1;
		hi = sb.acc_hi - 1;
		for (k = 0; k < pairs; k++) begin
			chs[k] = every_channel ? k + 1 : $urandom_range(1, NUM_CHANNELS - 1);
			if (hi >= lo && (every_channel || $urandom_range(0, 7) != 0))
				leads[k] = lo + int'($urandom_range(0, hi - lo));
			else
				leads[k] = rand_time();
			pick = every_channel ? 2 : $urandom_range(0, 7);
			case (pick)
				0: tot = int'($urandom_range(0, sb.spike));
				1: tot = -int'($urandom_range(1, 50000));
				default: tot = sb.spike + 1
					+ int'($urandom_range(0, $urandom_range(0, 1) ? 400000 : 3000));
			endcase
			f = longint'(leads[k]) + tot;
			if (f > TIME_TOP) f = TIME_TOP;
			if (f < TIME_BOTTOM) f = TIME_BOTTOM;
			falls[k] = int'(f);
		end
		grouped = $urandom_range(0, 1);
		if (grouped) begin
			for (k = 0; k < pairs; k++) begin
				if ($urandom_range(0, 5) == 0) send_noise();
				send_item(OP_EDGE, chs[k], 1'b1, leads[k]);
			end
			for (k = 0; k < pairs; k++) begin
				if ($urandom_range(0, 5) == 0) send_noise();
				send_item(OP_EDGE, chs[k], 1'b0, falls[k]);
			end
		end else begin
			for (k = 0; k < pairs; k++) begin
				if ($urandom_range(0, 5) == 0) send_noise();
				send_item(OP_EDGE, chs[k], 1'b1, leads[k]);
				send_item(OP_EDGE, chs[k], 1'b0, falls[k]);
			end
		end
		send_item(OP_END, $urandom_range(0, 255), $urandom_range(0, 1), rand_time());
	endtask

	// Receiver: random stall per result while rx_gaps is set, long hold on request
	initial begin : result_sink
		int stall_left;
		hit_rec_t got;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.hit = m_tuser[0];
				got.chan = m_tdata[7:0];
				got.lead = m_tdata[31:8];
				got.tot = m_tdata[54:32];
				got.evt = m_tdata[86:55];
				got.rises = m_tdata[102:87];
				got.last = m_tlast;
				sb.check_hit(got);
				stall_left = rx_gaps ? $urandom_range(0, 17) : 0;
			end
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int a_lo;
		int a_hi;
		int sp;
		int c_lo;
		int c_hi;
		int t_lim;
		int start;
		sb = new();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		hold_req = 0;
		edge_reqs = 0;
		end_reqs = 0;
		analysed_items = 0;
		phases_run = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_EDGE;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Writes to unused indexes must leave the defaults alone
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		cfg_we <= 1'b0;

		// Directed event set under the default window and cuts
		send_item(OP_END, 0, 1'b0, 0);
		send_item(OP_EDGE, 1, 1'b1, 0);
		send_item(OP_EDGE, 1, 1'b0, 100000);
		send_item(OP_EDGE, 1, 1'b1, 10);
		send_item(OP_EDGE, 1, 1'b0, 300000);
		send_item(OP_EDGE, 2, 1'b1, 1000);
		send_item(OP_EDGE, 2, 1'b0, 81000);
		send_item(OP_EDGE, 2, 1'b1, 2000);
		send_item(OP_EDGE, 2, 1'b0, 202000);
		send_item(OP_EDGE, 3, 1'b0, 5);
		send_item(OP_EDGE, 4, 1'b1, -800000);
		send_item(OP_EDGE, 4, 1'b1, 800000);
		send_item(OP_EDGE, 4, 1'b1, -799999);
		send_item(OP_EDGE, 4, 1'b0, -709999);
		send_item(OP_EDGE, 0, 1'b1, 0);
		send_item(OP_EDGE, 255, 1'b1, 0);
		send_item(OP_EDGE, NUM_CHANNELS, 1'b1, 0);
		send_item(OP_EDGE, 5, 1'b1, 500);
		send_item(OP_EDGE, 5, 1'b0, 100);
		send_item(OP_EDGE, NUM_CHANNELS - 1, 1'b1, 799999);
		send_item(OP_EDGE, NUM_CHANNELS - 1, 1'b0, TIME_TOP);
		send_item(OP_EDGE, 6, 1'b1, TIME_BOTTOM);
		send_item(OP_END, 170, 1'b1, -1);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain();
			case (phase)
				1: begin
					a_lo = TIME_BOTTOM; a_hi = TIME_TOP; sp = 0;
					c_lo = TIME_BOTTOM; c_hi = TIME_TOP; t_lim = TOT_CEIL;
				end
				2: begin
					a_lo = -1000; a_hi = 1000; sp = 100;
					c_lo = -500; c_hi = 500; t_lim = 2000;
				end
				3: begin
					a_lo = TIME_BOTTOM; a_hi = TIME_TOP; sp = TOT_CEIL;
					c_lo = TIME_BOTTOM; c_hi = TIME_TOP; t_lim = TOT_CEIL;
				end
				4: begin
					a_lo = -800000; a_hi = 800000; sp = 0;
					c_lo = TIME_TOP; c_hi = TIME_BOTTOM; t_lim = 0;
				end
				5: begin
					a_lo = -int'($urandom_range(0, 3000000));
					a_hi = int'($urandom_range(1, 3000000));
					sp = $urandom_range(0, 200000);
					c_lo = -int'($urandom_range(0, 3000000));
					c_hi = $urandom_range(0, 3000000);
					t_lim = $urandom_range(100000, TOT_CEIL);
				end
				default: begin
					a_lo = int'($signed(ACCEPT_LOW_RST));
					a_hi = int'($signed(ACCEPT_HIGH_RST));
					sp = int'(SPIKE_MIN_RST);
					c_lo = int'($signed(CUT_LOW_RST));
					c_hi = int'($signed(CUT_HIGH_RST));
					t_lim = int'(TOT_LIMIT_RST);
				end
			endcase
			write_reg(REG_ACCEPT_LOW, a_lo);
			write_reg(REG_ACCEPT_HIGH, a_hi);
			write_reg(REG_SPIKE_MIN, sp);
			write_reg(REG_CUT_LOW, c_lo);
			write_reg(REG_CUT_HIGH, c_hi);
			write_reg(REG_TOT_LIMIT, t_lim);
			cfg_we <= 1'b0;
			phases_run++;

			if (phase == 1) begin
				// Saturating and near-saturating pulse widths over the full window
				send_item(OP_EDGE, 7, 1'b1, TIME_BOTTOM + 1);
				send_item(OP_EDGE, 7, 1'b0, TIME_TOP);
				send_item(OP_EDGE, 8, 1'b1, 0);
				send_item(OP_EDGE, 8, 1'b0, TIME_TOP);
				send_item(OP_EDGE, 9, 1'b1, TIME_BOTTOM + 1);
				send_item(OP_EDGE, 9, 1'b0, -1);
				send_item(OP_END, 255, 1'b1, TIME_TOP);
				// Hold the receiver off while a full event and more are offered
				hold_req = LONG_HOLD;
				play_event(NUM_CHANNELS - 1, 1'b1);
				play_event($urandom_range(1, 6), 1'b0);
			end

			start = analysed_items;
			while (analysed_items - start < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					play_event($urandom_range(7, NUM_CHANNELS - 1), 1'b0);
				else
					play_event($urandom_range(0, 6), 1'b0);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.close_out();
		$display("Sent %0d edge requests and %0d end-of-event requests over %0d settings,",
			edge_reqs, end_reqs, phases_run);
		$display("one event under a long receiver hold; checked %0d hits, %0d empty markers.",
			sb.hits_seen, sb.empties_seen);
		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: tdc_edge_pair_hit_builder_top.f
rtl/tdc_ehb_pkg.sv
rtl/tdc_ehb_store.sv
rtl/tdc_edge_pair_hit_builder_top.sv
bench/tdc_edge_pair_hit_builder_top_test.sv
